/* hdl/sfpr_pkg.sv */
`default_nettype none

package sfpr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h62;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_CSUM = 2'd2,
        KIND_LONG = 2'd3
    } t_kind;

    typedef struct packed {
        logic [LEN_W-1:0]  byte_index;
        logic [LEN_W-1:0]  payload_len;
        logic [BYTE_W-1:0] msg_id;
        logic [BYTE_W-1:0] class_id;
        logic [BYTE_W-1:0] out_data;
        t_kind             kind;
    } t_result;

endpackage : sfpr_pkg

`default_nettype wire

/* hdl/sfpr_parser.sv */
`default_nettype none

module sfpr_parser
    import sfpr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    input  wire logic [BYTE_W-1:0]    i_byte,
    output logic                      o_res_valid,
    output t_result                   o_res
);

    typedef enum logic [8:0] {
        PH_SYNC1 = 9'b000000001,
        PH_SYNC2 = 9'b000000010,
        PH_CLASS = 9'b000000100,
        PH_MSG   = 9'b000001000,
        PH_LENLO = 9'b000010000,
        PH_LENHI = 9'b000100000,
        PH_DATA  = 9'b001000000,
        PH_CKA   = 9'b010000000,
        PH_CKB   = 9'b100000000
    } t_phase;

    logic [BYTE_W-1:0] r_sync_first, r_sync_second;
    logic [LEN_W-1:0]  r_max_payload;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_sum_a, n_sum_a, r_sum_b, n_sum_b;
    logic [BYTE_W-1:0] r_class, n_class, r_msg, n_msg, r_check_a, n_check_a;
    logic [LEN_W-1:0]  r_len, n_len, r_seen, n_seen;

    logic [BYTE_W-1:0] add_a, add_b;
    logic [LEN_W-1:0]  len_full, seen_inc;

    assign add_a    = r_sum_a + i_byte;
    assign add_b    = r_sum_b + add_a;
    assign len_full = {i_byte, r_len[BYTE_W-1:0]};
    assign seen_inc = r_seen + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data[BYTE_W-1:0];
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_class     = r_class;
        n_msg       = r_msg;
        n_len       = r_len;
        n_seen      = r_seen;
        n_check_a   = r_check_a;
        o_res_valid = 1'b0;
        o_res.kind        = KIND_DATA;
        o_res.out_data    = '0;
        o_res.byte_index  = '0;
        case (r_phase)
            PH_SYNC2: begin
                if (i_byte == r_sync_second) begin
                    n_phase = PH_CLASS;
                    n_sum_a = '0;
                    n_sum_b = '0;
                    n_seen  = '0;
                end else if (i_byte != r_sync_first) begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_CLASS: begin
                n_class = i_byte;
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_phase = PH_MSG;
            end
            PH_MSG: begin
                n_msg   = i_byte;
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_phase = PH_LENLO;
            end
            PH_LENLO: begin
                n_len   = {{(LEN_W-BYTE_W){1'b0}}, i_byte};
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_phase = PH_LENHI;
            end
            PH_LENHI: begin
                n_len   = len_full;
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_seen  = '0;
                if (len_full > r_max_payload) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_LONG;
                    n_phase     = PH_SYNC1;
                end else if (len_full == '0) begin
                    n_phase = PH_CKA;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_sum_a          = add_a;
                n_sum_b          = add_b;
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_DATA;
                o_res.out_data   = i_byte;
                o_res.byte_index = r_seen;
                n_seen           = seen_inc;
                if (seen_inc >= r_len) n_phase = PH_CKA;
            end
            PH_CKA: begin
                n_check_a = i_byte;
                n_phase   = PH_CKB;
            end
            PH_CKB: begin
                o_res_valid = 1'b1;
                if (r_check_a == r_sum_a && i_byte == r_sum_b) o_res.kind = KIND_GOOD;
                else o_res.kind = KIND_CSUM;
                n_phase = PH_SYNC1;
            end
            default: begin
                // also covers codes that are not a legal phase
                n_phase = (i_byte == r_sync_first) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
        // the only field taken from updated state is the length
        o_res.class_id    = r_class;
        o_res.msg_id      = r_msg;
        o_res.payload_len = n_len;
        o_res_valid       = o_res_valid & i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC1;
            r_sum_a   <= '0;
            r_sum_b   <= '0;
            r_class   <= '0;
            r_msg     <= '0;
            r_len     <= '0;
            r_seen    <= '0;
            r_check_a <= '0;
        end else if (i_valid) begin
            r_phase   <= n_phase;
            r_sum_a   <= n_sum_a;
            r_sum_b   <= n_sum_b;
            r_class   <= n_class;
            r_msg     <= n_msg;
            r_len     <= n_len;
            r_seen    <= n_seen;
            r_check_a <= n_check_a;
        end
    end

endmodule : sfpr_parser

`default_nettype wire

/* hdl/sync_framed_packet_receiver.sv */
// throughput: one byte per cycle while the skid register is empty; the parser state machine
//   and the checksum adders finish each byte in the cycle it is taken
// a two-entry output stage (result register plus skid register) keeps input flowing
//   while one result waits on the master side
// reset: synchronous, active low; all but the output payload registers return to their reset values, hunt for sync
`default_nettype none

module sync_framed_packet_receiver
    import sfpr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration writes: 0 sync_first, 1 sync_second, 2 max_payload
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // received byte stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [7:0] out_data, [15:8] class_id, [23:16] msg_id, [39:24] payload_len,
    // [55:40] byte_index
    output logic [55:0]               m_axis_tdata,
    output logic [KIND_W-1:0]         m_axis_tuser    // [1:0] kind
);

    logic    accept;
    logic    res_valid;
    t_result res;

    // result register and skid register
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    pop;

    // input is taken whenever the skid slot is free
    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;

    sfpr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (accept),
        .i_byte      (s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // control of the two-entry output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            // output slot frees up: skid drains first, else the new result goes straight out
            r_out_valid  <= r_skid_valid || res_valid;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            // output slot still held, park the new result
            r_skid_valid <= 1'b1;
        end
    end

    // payload of the output stage
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (r_out_valid && !pop && res_valid) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {r_out.byte_index, r_out.payload_len, r_out.msg_id,
                            r_out.class_id, r_out.out_data};

endmodule : sync_framed_packet_receiver

`default_nettype wire
